### design/imutcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imutcf_pkg: shared types and constants
// Register indexes, sequencer states, CORDIC angle table.
// ----------------------------------------------------------------------------
package imutcf_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int ITERS           = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int ITER_W          = 5;
    localparam int RND_SHIFT       = 16 - ANGLE_FRAC_BITS;

    localparam logic [2:0] REG_BLEND  = 3'd0;
    localparam logic [2:0] REG_GAIN   = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_OFFSET = 3'd3;
    localparam logic [2:0] REG_SCALE  = 3'd4;
    localparam logic [2:0] REG_SMOOTH = 3'd5;
    localparam logic [2:0] REG_LIMIT  = 3'd6;

    localparam logic signed [31:0] DEG90_Q16 = 32'sd5898240;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_SMOOTH_A,
        ST_SMOOTH_B,
        ST_RATE,
        ST_INTEG,
        ST_GAIN,
        ST_PRED,
        ST_BLEND_A,
        ST_BLEND_B,
        ST_DONE
    } state_t;

    function automatic logic [21:0] atan_lut(input logic [ITER_W-1:0] i);
        logic [21:0] v;
        begin
            case (i)
                5'd0:  v = 22'd2949120;
                5'd1:  v = 22'd1740967;
                5'd2:  v = 22'd919879;
                5'd3:  v = 22'd466945;
                5'd4:  v = 22'd234379;
                5'd5:  v = 22'd117304;
                5'd6:  v = 22'd58666;
                5'd7:  v = 22'd29335;
                5'd8:  v = 22'd14668;
                5'd9:  v = 22'd7334;
                5'd10: v = 22'd3667;
                5'd11: v = 22'd1833;
                5'd12: v = 22'd917;
                5'd13: v = 22'd458;
                5'd14: v = 22'd229;
                5'd15: v = 22'd115;
                5'd16: v = 22'd57;
                5'd17: v = 22'd29;
                5'd18: v = 22'd14;
                5'd19: v = 22'd7;
                5'd20: v = 22'd4;
                5'd21: v = 22'd2;
                5'd22: v = 22'd1;
                default: v = 22'd0;
            endcase
            atan_lut = v;
        end
    endfunction

endpackage

### design/imu_tilt_complementary_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter_core: accel/gyro tilt fusion
// CORDIC arctangent tilt plus a smoothed, integrated gyro rate, blended.
// ----------------------------------------------------------------------------
// A request runs the CORDIC loop, ITERS = min(CORDIC_STEPS, 24) iterations,
// then states SMOOTH_A, SMOOTH_B, RATE, INTEG, GAIN, PRED, BLEND_A, BLEND_B
// and DONE before the result is valid; when accel x is zero the CORDIC state
// is left without rotating. Requests are not overlapped: the rate is set by
// the CORDIC iterations and the single shared multiplier that serves all
// eight products in turn. s_tready is low while a request is in work; a
// finished result waits in the output register and the next request is taken
// after it leaves. Reset (rst_n low, async) clears the filter state, sequencer
// and restores register defaults.
module imu_tilt_complementary_filter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x[15:0], accel_z[31:16], gyro_y[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // fused_angle[15:0], tilt_from_accel[31:16],
                                   // scaled_rate[51:32], rate_integral[83:52]
);

    // configuration registers
    logic [15:0]        blend_reg, gain_reg, step_reg, scale_reg, smooth_reg;
    logic signed [15:0] offset_reg;
    logic [14:0]        limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg  <= 16'd492;
            gain_reg   <= 16'd60948;
            step_reg   <= 16'd328;
            offset_reg <= 16'sd1;
            scale_reg  <= 16'd3996;
            smooth_reg <= 16'd52429;
            limit_reg  <= 15'd23040;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                imutcf_pkg::REG_BLEND:  blend_reg  <= cfg_wdata;
                imutcf_pkg::REG_GAIN:   gain_reg   <= cfg_wdata;
                imutcf_pkg::REG_STEP:   step_reg   <= cfg_wdata;
                imutcf_pkg::REG_OFFSET: offset_reg <= cfg_wdata;
                imutcf_pkg::REG_SCALE:  scale_reg  <= cfg_wdata;
                imutcf_pkg::REG_SMOOTH: smooth_reg <= cfg_wdata;
                imutcf_pkg::REG_LIMIT:  limit_reg  <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // filter state
    logic signed [15:0] sgyro_reg, sgyro_next;
    logic signed [15:0] ftilt_reg, ftilt_next;
    logic signed [31:0] accum_reg, accum_next;

    // sequencer
    imutcf_pkg::state_t state_reg, state_next;
    logic [imutcf_pkg::ITER_W-1:0] iter_reg, iter_next;

    // working registers
    logic signed [25:0] cx_reg, cx_next, cz_reg, cz_next;  // CORDIC vectors
    logic signed [31:0] ang_reg, ang_next;
    logic               axis_reg, axis_next;               // x == 0 shortcut
    logic signed [15:0] gy_reg, gy_next;
    logic signed [15:0] tilt_reg, tilt_next;
    logic signed [35:0] acc_reg, acc_next;                 // partial sum
    logic signed [31:0] rate_reg, rate_next;
    logic signed [19:0] gain_out_reg, gain_out_next;
    logic signed [35:0] pred_reg, pred_next;
    logic               out_valid_reg, out_valid_next;
    logic [87:0]        out_data_reg, out_data_next;

    // shared multiplier; b holds 65536 - w, so it needs 18 bits
    logic signed [35:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [52:0] mul_p;

    imutcf_mac u_mac
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // round to nearest, ties up, by 2^16 / 2^RND_SHIFT
    function automatic logic signed [52:0] rnd16(input logic signed [52:0] v);
        rnd16 = (v + 53'sd32768) >>> 16;
    endfunction
    function automatic logic signed [52:0] rndf(input logic signed [52:0] v);
        rndf = (v + (53'sd1 <<< (imutcf_pkg::RND_SHIFT - 1))) >>> imutcf_pkg::RND_SHIFT;
    endfunction

    logic signed [52:0] r16, rf;
    assign r16 = rnd16(mul_p);
    assign rf  = rndf(mul_p);

    // CORDIC step
    logic signed [25:0] sh_x, sh_z;
    logic signed [31:0] atan_v;
    assign sh_x   = cx_reg >>> iter_reg;
    assign sh_z   = cz_reg >>> iter_reg;
    assign atan_v = 32'(signed'({1'b0, imutcf_pkg::atan_lut(iter_reg)}));

    // input unpack
    logic signed [15:0] in_ax, in_az, in_gy;
    logic signed [16:0] ax_abs, az_neg;
    assign in_ax  = s_tdata[15:0];
    assign in_az  = s_tdata[31:16];
    assign in_gy  = s_tdata[47:32];
    assign ax_abs = in_ax[15] ? -17'(in_ax) : 17'(in_ax);
    assign az_neg = in_ax[15] ? -17'(in_az) : 17'(in_az);

    assign s_tready = (state_reg == imutcf_pkg::ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // clamp helpers
    logic signed [31:0] ang_cl;
    logic signed [52:0] tsum;
    logic signed [52:0] sm_v, gn_v, fu_v;
    logic signed [15:0] lim_p, lim_n;
    assign ang_cl = (ang_reg > imutcf_pkg::DEG90_Q16) ? imutcf_pkg::DEG90_Q16 :
                    (ang_reg < -imutcf_pkg::DEG90_Q16) ? -imutcf_pkg::DEG90_Q16 : ang_reg;
    assign lim_p  = 16'(signed'({1'b0, limit_reg}));
    assign lim_n  = -lim_p;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imutcf_pkg::ST_IDLE:
                if (s_tvalid && s_tready) state_next = imutcf_pkg::ST_CORDIC;
            imutcf_pkg::ST_CORDIC:
                if (axis_reg || iter_reg == imutcf_pkg::ITER_W'(imutcf_pkg::ITERS - 1))
                    state_next = imutcf_pkg::ST_SMOOTH_A;
            imutcf_pkg::ST_SMOOTH_A: state_next = imutcf_pkg::ST_SMOOTH_B;
            imutcf_pkg::ST_SMOOTH_B: state_next = imutcf_pkg::ST_RATE;
            imutcf_pkg::ST_RATE:     state_next = imutcf_pkg::ST_INTEG;
            imutcf_pkg::ST_INTEG:    state_next = imutcf_pkg::ST_GAIN;
            imutcf_pkg::ST_GAIN:     state_next = imutcf_pkg::ST_PRED;
            imutcf_pkg::ST_PRED:     state_next = imutcf_pkg::ST_BLEND_A;
            imutcf_pkg::ST_BLEND_A:  state_next = imutcf_pkg::ST_BLEND_B;
            imutcf_pkg::ST_BLEND_B:  state_next = imutcf_pkg::ST_DONE;
            imutcf_pkg::ST_DONE:     state_next = imutcf_pkg::ST_IDLE;
            default:                 state_next = imutcf_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs. Each multiply is issued one state, used the next.
    always_comb
    begin
        iter_next      = iter_reg;
        cx_next        = cx_reg;
        cz_next        = cz_reg;
        ang_next       = ang_reg;
        axis_next      = axis_reg;
        gy_next        = gy_reg;
        tilt_next      = tilt_reg;
        acc_next       = acc_reg;
        rate_next      = rate_reg;
        gain_out_next  = gain_out_reg;
        pred_next      = pred_reg;
        sgyro_next     = sgyro_reg;
        ftilt_next     = ftilt_reg;
        accum_next     = accum_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_a          = '0;
        mul_b          = '0;
        tsum           = '0;
        sm_v           = '0;
        gn_v           = '0;
        fu_v           = '0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            imutcf_pkg::ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    iter_next = '0;
                    cx_next   = 26'(ax_abs) <<< 8;
                    cz_next   = 26'(az_neg) <<< 8;
                    gy_next   = in_gy;
                    axis_next = (in_ax == 16'sd0);
                    if (in_ax == 16'sd0)
                        ang_next = (in_az > 0) ? imutcf_pkg::DEG90_Q16 :
                                   (in_az < 0) ? -imutcf_pkg::DEG90_Q16 : 32'sd0;
                    else
                        ang_next = '0;
                end
            end
            imutcf_pkg::ST_CORDIC:
            begin
                if (!axis_reg)
                begin
                    if (cz_reg > 0)
                    begin
                        cx_next  = cx_reg + sh_z;
                        cz_next  = cz_reg - sh_x;
                        ang_next = ang_reg + atan_v;
                    end
                    else
                    begin
                        cx_next  = cx_reg - sh_z;
                        cz_next  = cz_reg + sh_x;
                        ang_next = ang_reg - atan_v;
                    end
                end
                iter_next = iter_reg + 1'b1;
            end
            imutcf_pkg::ST_SMOOTH_A:
            begin
                tsum      = 53'(ang_cl) + (53'sd1 <<< (imutcf_pkg::RND_SHIFT - 1));
                tilt_next = 16'(tsum >>> imutcf_pkg::RND_SHIFT);
                mul_a     = 36'(sgyro_reg);
                mul_b     = 18'(signed'({1'b0, smooth_reg}));
            end
            imutcf_pkg::ST_SMOOTH_B:
            begin
                acc_next = 36'(mul_p);
                mul_a    = 36'(gy_reg);
                mul_b    = 18'sd65536 - 18'(signed'({1'b0, smooth_reg}));
            end
            imutcf_pkg::ST_RATE:
            begin
                sm_v = rnd16(53'(acc_reg) + mul_p);
                if (sm_v > 53'sd32767)       sgyro_next = 16'sh7fff;
                else if (sm_v < -53'sd32768) sgyro_next = 16'sh8000;
                else                         sgyro_next = 16'(sm_v);
                mul_a = 36'(sgyro_next) - 36'(offset_reg);
                mul_b = 18'(signed'({1'b0, scale_reg}));
            end
            imutcf_pkg::ST_INTEG:
            begin
                rate_next = 32'(rf);
                mul_a     = 36'(rate_next);
                mul_b     = 18'(signed'({1'b0, step_reg}));
            end
            imutcf_pkg::ST_GAIN:
            begin
                sm_v = 53'(accum_reg) + r16;
                if (sm_v > 53'sd2147483647)       accum_next = 32'sh7fffffff;
                else if (sm_v < -53'sd2147483648) accum_next = 32'sh80000000;
                else                              accum_next = 32'(sm_v);
                mul_a = 36'(rate_reg);
                mul_b = 18'(signed'({1'b0, gain_reg}));
            end
            imutcf_pkg::ST_PRED:
            begin
                gn_v = r16;
                if (gn_v > 53'sd524287)       gain_out_next = 20'sh7ffff;
                else if (gn_v < -53'sd524288) gain_out_next = 20'sh80000;
                else                          gain_out_next = 20'(gn_v);
                mul_a = 36'(gain_out_next);
                mul_b = 18'(signed'({1'b0, step_reg}));
            end
            imutcf_pkg::ST_BLEND_A:
            begin
                pred_next = 36'(ftilt_reg) + 36'(r16);
                mul_a     = 36'(tilt_reg);
                mul_b     = 18'(signed'({1'b0, blend_reg}));
            end
            imutcf_pkg::ST_BLEND_B:
            begin
                acc_next = 36'(mul_p);
                mul_a    = pred_reg;
                mul_b    = 18'sd65536 - 18'(signed'({1'b0, blend_reg}));
            end
            imutcf_pkg::ST_DONE:
            begin
                fu_v = rnd16(53'(acc_reg) + mul_p);
                if (fu_v > 53'(lim_p))      ftilt_next = lim_p;
                else if (fu_v < 53'(lim_n)) ftilt_next = lim_n;
                else                        ftilt_next = 16'(fu_v);
                out_valid_next = 1'b1;
                out_data_next  = {4'b0, accum_reg, gain_out_reg, tilt_reg, ftilt_next};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imutcf_pkg::ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            sgyro_reg     <= '0;
            ftilt_reg     <= '0;
            accum_reg     <= '0;
            axis_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            sgyro_reg     <= sgyro_next;
            ftilt_reg     <= ftilt_next;
            accum_reg     <= accum_next;
            axis_reg      <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cz_reg       <= cz_next;
        ang_reg      <= ang_next;
        gy_reg       <= gy_next;
        tilt_reg     <= tilt_next;
        acc_reg      <= acc_next;
        rate_reg     <= rate_next;
        gain_out_reg <= gain_out_next;
        pred_reg     <= pred_next;
        out_data_reg <= out_data_next;
    end

endmodule

### design/imutcf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imutcf_mac: shared signed multiplier with a registered product
// One 36 x 18 signed multiply per cycle.
// ----------------------------------------------------------------------------
module imutcf_mac
(
    input  logic                clk,
    input  logic signed [35:0]  a,
    input  logic signed [17:0]  b,
    output logic signed [52:0]  p
);

    logic signed [52:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 53'(a) * 53'(b);
    end

    assign p = p_reg;

endmodule
